// ===== rtl/rtp_retransmit_store_defines.svh =====
// assertion macros of the retransmit store checker
`ifndef RTP_RETRANSMIT_STORE_DEFINES_SVH
`define RTP_RETRANSMIT_STORE_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define RTPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define RTPS_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/rtps_pkg.sv =====
// types and constants of the retransmit store
`default_nettype none

package rtps_pkg;

    // operation codes
    localparam logic OP_SAVE   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // largest packet length kept
    localparam logic [10:0] MAX_PACKET_LEN = 11'd1500;

    typedef struct packed {
        logic        operation;
        logic        eye;
        logic [15:0] seq_no;
        logic [10:0] length;
    } req_t;

    typedef struct packed {
        logic        stored;
        logic        found;
        logic [1:0]  store_slot;
        logic [9:0]  entry_slot;
        logic [10:0] packet_length;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/rtps_if.sv =====
// request and response channel interfaces of the retransmit store
`default_nettype none

interface rtps_req_if import rtps_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rtps_rsp_if import rtps_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rtp_retransmit_store.sv =====
// retransmit store bookkeeping: ring of stores per stream, save and lookup
//
// Usage:
//   req carries one transaction per packet: a save (stream, sequence number,
//   length) or a lookup of a lost sequence number. rsp returns exactly one
//   transaction per request, in order: the store and entry written by a save,
//   or found, store, entry and recorded length of a lookup.
//   cfg_wr_en / cfg_wr_data write save_enable; write it only while idle.
//   A request passes the input register, then the result register with the
//   length memory read, before its response is valid. Throughput is one
//   transaction per cycle while rsp is not stalled; the limit is the single
//   read/write port of the length memory, used once per transaction.
//   When rsp is stalled the result register holds, the input register fills
//   and req.ready drops once both are occupied; nothing is lost.
//   Reset clears ring pointers, store begins and counts and sets
//   save_enable; the length memory is not cleared, since only entries below
//   a store's count are ever read. No clearing pass is needed after reset.
`default_nettype none

module rtp_retransmit_store
    import rtps_pkg::*;
#(
    parameter int STORES            = 4,
    parameter int ENTRIES_PER_STORE = 1024
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    rtps_req_if.sink        req,
    rtps_rsp_if.source      rsp,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data
);

    localparam int SW    = $clog2(STORES);
    localparam int EW    = $clog2(ENTRIES_PER_STORE);
    localparam int CW    = $clog2(ENTRIES_PER_STORE + 1);
    localparam int DEPTH = 2 * STORES * ENTRIES_PER_STORE;
    localparam int AW    = $clog2(DEPTH);

    // flat address of an entry in the length memory
    function automatic logic [AW-1:0] mem_addr(input logic e, input logic [SW-1:0] s,
                                               input logic [EW-1:0] n);
        return AW'(e) * AW'(STORES * ENTRIES_PER_STORE)
             + AW'(s) * AW'(ENTRIES_PER_STORE) + AW'(n);
    endfunction

    // configuration
    logic save_enable_reg;

    // ring state per stream
    logic [SW-1:0] cur_reg     [2];
    logic [15:0]   beg_seq_reg [2][STORES];
    logic [CW-1:0] cnt_reg     [2][STORES];

    // length memory and its registered read
    logic [10:0]   len_mem [DEPTH];
    logic [10:0]   rd_len_reg;

    // input stage
    logic          a_valid_reg;
    req_t          a_data_reg;

    // result stage
    logic          b_valid_reg;
    logic          b_stored_reg;
    logic          b_found_reg;
    logic [SW-1:0] b_store_reg;
    logic [EW-1:0] b_entry_reg;
    logic [10:0]   b_len_reg;
    logic          b_use_mem_reg;

    // combinational work of the input stage
    logic          advance;
    logic          fire_a;
    logic          do_save;
    logic [10:0]   len_sat;
    logic [SW-1:0] sv_store;
    logic [EW-1:0] sv_slot;
    logic          hit;
    logic [SW-1:0] hit_store;
    logic [EW-1:0] hit_entry;
    logic [AW-1:0] addr;
    logic [31:0]   store_wide;
    logic [31:0]   entry_wide;

    // handshake: result register advances when empty or taken
    assign advance   = !b_valid_reg || rsp.ready;
    assign req.ready = !a_valid_reg || advance;
    assign fire_a    = a_valid_reg && advance;

    // save path and lookup path
    always_comb
    begin
        logic          eye;
        logic [15:0]   seq;
        logic [SW-1:0] cur;
        logic [CW-1:0] cur_cnt;
        logic          full;
        logic [SW-1:0] nxt;
        logic [16:0]   top;
        logic [15:0]   diff;

        eye     = a_data_reg.eye;
        seq     = a_data_reg.seq_no;
        do_save = (a_data_reg.operation == OP_SAVE) && save_enable_reg;
        len_sat = (a_data_reg.length > MAX_PACKET_LEN) ? MAX_PACKET_LEN : a_data_reg.length;

        // current store, move on when full
        cur      = cur_reg[eye];
        cur_cnt  = cnt_reg[eye][cur];
        full     = (cur_cnt == CW'(ENTRIES_PER_STORE));
        nxt      = (cur == SW'(STORES - 1)) ? '0 : cur + 1'b1;
        sv_store = full ? nxt : cur;
        sv_slot  = full ? '0 : cur_cnt[EW-1:0];

        // range check of every store, last match wins
        hit       = 1'b0;
        hit_store = '0;
        hit_entry = '0;
        for (int i = 0; i < STORES; i++)
        begin
            top  = {1'b0, beg_seq_reg[eye][i]} + 17'(cnt_reg[eye][i]);
            diff = seq - beg_seq_reg[eye][i];
            if ((seq >= beg_seq_reg[eye][i]) && ({1'b0, seq} < top))
            begin
                hit       = 1'b1;
                hit_store = SW'(i);
                hit_entry = diff[EW-1:0];
            end
        end

        addr = do_save ? mem_addr(eye, sv_store, sv_slot) : mem_addr(eye, hit_store, hit_entry);
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            save_enable_reg <= 1'b1;
        else if (cfg_wr_en)
            save_enable_reg <= cfg_wr_data;
    end

    // ring pointers, begins and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < 2; e++)
            begin
                cur_reg[e] <= '0;
                for (int i = 0; i < STORES; i++)
                begin
                    beg_seq_reg[e][i] <= '0;
                    cnt_reg[e][i]     <= '0;
                end
            end
        end
        else if (fire_a && do_save)
        begin
            cur_reg[a_data_reg.eye]           <= sv_store;
            cnt_reg[a_data_reg.eye][sv_store] <= CW'(sv_slot) + 1'b1;
            if (sv_slot == '0)
                beg_seq_reg[a_data_reg.eye][sv_store] <= a_data_reg.seq_no;
        end
    end

    // length memory: one write or one read per transaction
    always_ff @(posedge clk)
    begin
        if (fire_a && do_save)
            len_mem[addr] <= len_sat;
        if (advance)
            rd_len_reg <= len_mem[addr];
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (req.ready)
            a_valid_reg <= req.valid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
            a_data_reg <= req.data;
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (advance)
            b_valid_reg <= a_valid_reg;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (a_data_reg.operation == OP_SAVE)
            begin
                b_stored_reg  <= do_save;
                b_found_reg   <= 1'b0;
                b_store_reg   <= do_save ? sv_store : '0;
                b_entry_reg   <= do_save ? sv_slot : '0;
                b_len_reg     <= do_save ? len_sat : '0;
                b_use_mem_reg <= 1'b0;
            end
            else
            begin
                b_stored_reg  <= 1'b0;
                b_found_reg   <= hit;
                b_store_reg   <= hit_store;
                b_entry_reg   <= hit_entry;
                b_len_reg     <= '0;
                b_use_mem_reg <= hit;
            end
        end
    end

    // response fields, slots masked to their field widths
    assign store_wide = 32'(b_store_reg);
    assign entry_wide = 32'(b_entry_reg);

    assign rsp.valid              = b_valid_reg;
    assign rsp.data.stored        = b_stored_reg;
    assign rsp.data.found         = b_found_reg;
    assign rsp.data.store_slot    = store_wide[1:0];
    assign rsp.data.entry_slot    = entry_wide[9:0];
    assign rsp.data.packet_length = b_use_mem_reg ? rd_len_reg : b_len_reg;

endmodule

`default_nettype wire

// ===== rtl/rtps_checker.sv =====
// port checker of the retransmit store and its bind
`default_nettype none

`include "rtp_retransmit_store_defines.svh"

module rtps_checker
    import rtps_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rsp_t rsp_data
);

    // a stalled response transaction holds
    `RTPS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "rsp changed while stalled")

    // a response is either a save or a lookup hit, never both
    `RTPS_ASSERT_NEVER(a_one_kind, rsp_valid && rsp_data.stored && rsp_data.found, "stored and found both set")

    // a rejected save or lookup miss reports all zero
    `RTPS_ASSERT(a_miss_zero, rsp_valid && !rsp_data.stored && !rsp_data.found |-> rsp_data.store_slot == 2'd0 && rsp_data.entry_slot == 10'd0 && rsp_data.packet_length == 11'd0, "miss with nonzero fields")

    // reported length never passes the cap
    `RTPS_ASSERT_NEVER(a_len_cap, rsp_valid && rsp_data.packet_length > MAX_PACKET_LEN, "length above cap")

endmodule

bind rtp_retransmit_store rtps_checker u_rtps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

`default_nettype wire
